// ===== hw/rtl/psdp_pkg.sv =====
// Shared types and constants for the precision select dot product block.
package psdp_pkg;

	// Payload widths.
	localparam int CMD_W      = 2;
	localparam int ROW_W      = 5;
	localparam int WIDX_IN_W  = 4;
	localparam int DATA_W     = 64;
	localparam int SUM_W      = 23;
	localparam int ACT_W      = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W     = 2;

	// Byte lanes and their products.
	localparam int LANES       = 8;
	localparam int BYTE_W      = 8;
	localparam int LANE_PROD_W = 16;
	localparam int WORD_SUM_W  = 19;
	localparam int WORD_SUM_MAX = 520200;

	localparam logic [SUM_W-1:0] SUM_MAX = 23'h7F_FFFF;
	localparam logic [ACT_W-1:0] ACT_MAX = 4'hF;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_KWRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FWRITE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 2'd1;

	// Lane widths selected by the precision register.
	localparam logic [MODE_W-1:0] MODE_BIT1 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BIT2 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIT4 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BIT8 = 2'd3;

	typedef logic [MODE_W-1:0]      mode_t;
	typedef logic [LANE_PROD_W-1:0] lane_prod_t;

	// Control that travels alongside each word through the datapath.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} beat_t;

endpackage

// ===== hw/rtl/psdp_lane.sv =====
// One byte lane: sub-word products of a kernel byte and a feature byte.
module psdp_lane (
	input  logic                           clk,
	input  psdp_pkg::mode_t                mode,
	input  logic [psdp_pkg::BYTE_W-1:0]    kbyte,
	input  logic [psdp_pkg::BYTE_W-1:0]    fbyte,
	output psdp_pkg::lane_prod_t           prod_s2
);
	import psdp_pkg::*;

	lane_prod_t prod;

	always_comb begin
		prod = '0;
		case (mode)
			MODE_BIT1: begin
				for (int i = 0; i < BYTE_W; i++) begin
					prod = prod + LANE_PROD_W'(kbyte[i] & fbyte[i]);
				end
			end
			MODE_BIT2: begin
				for (int i = 0; i < BYTE_W / 2; i++) begin
					prod = prod + LANE_PROD_W'(kbyte[2*i +: 2]) * LANE_PROD_W'(fbyte[2*i +: 2]);
				end
			end
			MODE_BIT4: begin
				prod = LANE_PROD_W'(kbyte[3:0]) * LANE_PROD_W'(fbyte[3:0])
					+ LANE_PROD_W'(kbyte[7:4]) * LANE_PROD_W'(fbyte[7:4]);
			end
			MODE_BIT8: begin
				prod = LANE_PROD_W'(kbyte) * LANE_PROD_W'(fbyte);
			end
			default: begin
				prod = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
	end

endmodule

// ===== hw/rtl/psdp_merge.sv =====
// Merging stage: adds the eight lane products and accumulates over a row.
module psdp_merge #(
	parameter int ACC_W = 24
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  psdp_pkg::lane_prod_t [psdp_pkg::LANES-1:0] prod_s2,
	input  psdp_pkg::beat_t                           beat_s2,
	output logic [ACC_W-1:0]                          acc,
	output logic                                      done
);
	import psdp_pkg::*;

	logic [WORD_SUM_W-1:0] word_sum;
	logic [WORD_SUM_W-1:0] word_sum_s3;
	beat_t                 beat_s3;
	logic [ACC_W-1:0]      acc_q;
	logic                  done_q;

	always_comb begin
		word_sum = '0;
		for (int l = 0; l < LANES; l++) begin
			word_sum = word_sum + WORD_SUM_W'(prod_s2[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s3 <= '0;
			done_q  <= 1'b0;
		end else begin
			beat_s3 <= beat_s2;
			done_q  <= beat_s3.vld && beat_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		word_sum_s3 <= word_sum;
		if (beat_s3.vld) begin
			if (beat_s3.first) begin
				acc_q <= ACC_W'(word_sum_s3);
			end else begin
				acc_q <= acc_q + ACC_W'(word_sum_s3);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/precision_select_dot_product.sv =====
// Top level of the precision select dot product engine.
// The block holds ROW_COUNT kernel rows and one feature vector, each ROW_BYTES/8 words of
// 64 bits. A write transaction (command 0 or 1) stores one word and gives no result;
// command 3 is taken and ignored. A compute transaction (command 2) streams the selected
// row and the feature vector out of their memories one word per cycle, then waits for the
// merging stage to finish the row and in the finishing state until the output register
// can take the result; the compute occupies the block until then. Eight byte lanes form
// the sub-word products of each word in parallel and a merging stage adds them and
// accumulates over the row. The sum saturates at 23 bits and the bias is added and
// clamped to 0..15. The result sits in an output register, so writes and the next compute
// are taken while it waits. After reset both memories are swept to zero, one kernel entry
// per cycle, over all ROW_COUNT * 2**ceil(log2(ROW_WORDS)) kernel entries (512 at the
// default size); no input transaction is taken during the sweep, while configuration
// writes are taken at any time.
module precision_select_dot_product #(
	parameter int ROW_BYTES = 128,
	parameter int ROW_COUNT = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [psdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psdp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [psdp_pkg::CMD_W-1:0]         command,
	input  logic [psdp_pkg::ROW_W-1:0]         row,
	input  logic [psdp_pkg::WIDX_IN_W-1:0]     word_index,
	input  logic [psdp_pkg::DATA_W-1:0]        data,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [psdp_pkg::ROW_W-1:0]         row_used,
	output logic [psdp_pkg::SUM_W-1:0]         partial_sum,
	output logic [psdp_pkg::ACT_W-1:0]         activation
);
	import psdp_pkg::*;

	localparam int ROW_WORDS  = ROW_BYTES / 8;
	localparam int WIDX_W     = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int FMEM_DEPTH = 1 << WIDX_W;
	localparam int RIDX_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int KADDR_W    = RIDX_W + WIDX_W;
	localparam int KMEM_DEPTH = ROW_COUNT * FMEM_DEPTH;
	localparam int ACC_RAW_W  = $clog2(ROW_WORDS * WORD_SUM_MAX + 1);
	localparam int ACC_W      = (ACC_RAW_W > SUM_W) ? ACC_RAW_W : SUM_W + 1;
	localparam int ROW_VALS   = 1 << ROW_W;

	localparam logic [WIDX_W-1:0]  LAST_WORD  = WIDX_W'(ROW_WORDS - 1);
	localparam logic [KADDR_W-1:0] LAST_CLEAR = KADDR_W'(KMEM_DEPTH - 1);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic [KADDR_W-1:0]    clr_q;
	logic [WIDX_W-1:0]     wcnt_q;
	logic [RIDX_W-1:0]     rsel_q;
	logic [ROW_W-1:0]      row_q;
	mode_t                 mode_q;
	logic [CFG_DATA_W-1:0] bias_q;

	logic                  out_valid_q;
	logic [ROW_W-1:0]      row_used_q;
	logic [SUM_W-1:0]      partial_sum_q;
	logic [ACT_W-1:0]      activation_q;

	// Row number reduced modulo the number of stored rows, as a constant table.
	logic [RIDX_W-1:0] row_mod [ROW_VALS];

	always_comb begin
		for (int i = 0; i < ROW_VALS; i++) begin
			row_mod[i] = RIDX_W'(i % ROW_COUNT);
		end
	end

	// Input decode.
	logic              in_take;
	logic              widx_ok;
	logic [WIDX_W-1:0] widx;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign widx_ok  = {{(32 - WIDX_IN_W){1'b0}}, word_index} < 32'(ROW_WORDS);
	assign widx     = WIDX_W'(word_index);

	// Memory write and read controls. Writes only happen during the sweep or when idle, so
	// they never collide with the reads of a compute.
	logic               clearing;
	logic               k_we;
	logic               f_we;
	logic [KADDR_W-1:0] k_waddr;
	logic [WIDX_W-1:0]  f_waddr;
	logic [DATA_W-1:0]  wdata;
	logic [KADDR_W-1:0] k_raddr;

	assign clearing = (state_q == ST_CLEAR);
	assign k_we     = clearing || (in_take && command == CMD_KWRITE && widx_ok);
	assign f_we     = (clearing && clr_q[KADDR_W-1:WIDX_W] == '0)
		|| (in_take && command == CMD_FWRITE && widx_ok);
	assign k_waddr  = clearing ? clr_q : {row_mod[row], widx};
	assign f_waddr  = clearing ? clr_q[WIDX_W-1:0] : widx;
	assign wdata    = clearing ? '0 : data;
	assign k_raddr  = {rsel_q, wcnt_q};

	logic [DATA_W-1:0] kmem [KMEM_DEPTH];
	logic [DATA_W-1:0] fmem [FMEM_DEPTH];
	logic [DATA_W-1:0] kdat_s1;
	logic [DATA_W-1:0] fdat_s1;

	always_ff @(posedge clk) begin
		if (k_we) begin
			kmem[k_waddr] <= wdata;
		end
		kdat_s1 <= kmem[k_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_waddr] <= wdata;
		end
		fdat_s1 <= fmem[wcnt_q];
	end

	// Word tags follow the read data down the pipeline.
	beat_t beat_s1;
	beat_t beat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			beat_s2 <= '0;
		end else begin
			beat_s1.vld   <= (state_q == ST_RUN);
			beat_s1.first <= (wcnt_q == '0);
			beat_s1.last  <= (wcnt_q == LAST_WORD);
			beat_s2       <= beat_s1;
		end
	end

	// Byte lanes.
	lane_prod_t [LANES-1:0] prod_s2;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		psdp_lane u_lane (
			.clk     (clk),
			.mode    (mode_q),
			.kbyte   (kdat_s1[l*BYTE_W +: BYTE_W]),
			.fbyte   (fdat_s1[l*BYTE_W +: BYTE_W]),
			.prod_s2 (prod_s2[l])
		);
	end

	logic [ACC_W-1:0] acc_sum;
	logic             merge_done;

	psdp_merge #(
		.ACC_W (ACC_W)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod_s2 (prod_s2),
		.beat_s2 (beat_s2),
		.acc     (acc_sum),
		.done    (merge_done)
	);

	// Saturate the row sum, then add the bias and clamp to the activation range.
	logic [SUM_W-1:0]          sum_sat;
	logic signed [CFG_DATA_W+1:0] act_wide;
	logic [ACT_W-1:0]          act;

	always_comb begin
		if (acc_sum > ACC_W'(SUM_MAX)) begin
			sum_sat = SUM_MAX;
		end else begin
			sum_sat = acc_sum[SUM_W-1:0];
		end
		act_wide = $signed({{(CFG_DATA_W + 2 - SUM_W){1'b0}}, sum_sat})
			+ $signed({{2{bias_q[CFG_DATA_W-1]}}, bias_q});
		if (act_wide[CFG_DATA_W+1]) begin
			act = '0;
		end else if (act_wide > $signed((CFG_DATA_W + 2)'(ACT_MAX))) begin
			act = ACT_MAX;
		end else begin
			act = act_wide[ACT_W-1:0];
		end
	end

	logic out_load;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wcnt_q  <= '0;
			rsel_q  <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_CLEAR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take && command == CMD_COMPUTE) begin
						row_q   <= row;
						rsel_q  <= row_mod[row];
						wcnt_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == LAST_WORD) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (merge_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds a finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			row_used_q    <= row_q;
			partial_sum_q <= sum_sat;
			activation_q  <= act;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_used    = row_used_q;
	assign partial_sum = partial_sum_q;
	assign activation  = activation_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BIT8;
			bias_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRECISION: mode_q <= cfg_data[MODE_W-1:0];
				CFG_BIAS:      bias_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A new result only ever comes out of the finishing state.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the finishing state");

	// The merging stage only completes a row while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		merge_done |-> state_q == ST_WAIT)
		else $error("row completed while the sequencer was not waiting");

	// The pipeline has drained by the time a result is finished.
	a_drained_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !beat_s1.vld && !beat_s2.vld)
		else $error("words still in flight at finish");

	// No result can exist while the memories are being swept.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q && !beat_s1.vld)
		else $error("activity during the clearing sweep");

endmodule
